@@ rtl/bpgd_pkg.sv @@
package bpgd_pkg;

    localparam int unsigned TsW    = 32;
    localparam int unsigned MsW    = 16;
    localparam int unsigned CntW   = 5;
    localparam int unsigned TgtW   = 4;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] GEST_NONE      = 2'd0;
    localparam logic [1:0] GEST_ERASE     = 2'd1;
    localparam logic [1:0] GEST_ARMED     = 2'd2;
    localparam logic [1:0] GEST_PROVISION = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_ERASE_HOLD   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_MAX    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TARGET       = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SEQ_WINDOW   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_QUIET_GAP    = 3'd4;

    localparam logic [MsW-1:0]  RST_ERASE_HOLD = 16'd10000;
    localparam logic [MsW-1:0]  RST_SHORT_MAX  = 16'd1000;
    localparam logic [TgtW-1:0] RST_TARGET     = 4'd3;
    localparam logic [MsW-1:0]  RST_SEQ_WINDOW = 16'd5000;
    localparam logic [MsW-1:0]  RST_QUIET_GAP  = 16'd1500;

    localparam logic [CntW-1:0] PRESS_SAT = 5'd16;

    typedef struct packed {
        logic [1:0]     operation;
        logic [TsW-1:0] timestamp_ms;
    } t_bpgd_in;

    typedef struct packed {
        logic [1:0] gesture;
        logic       busy_res;
    } t_bpgd_out;

endpackage

@@ rtl/button_press_gesture_detector_unit.sv @@
// Each input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle; input stalls only while the result
// register is full and not taken.
// Reset (i_rst_n low, synchronous): key and run state cleared, registers back to
// defaults, both pipeline registers emptied. Config port is always ready.
module button_press_gesture_detector_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bpgd_pkg::t_bpgd_in           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bpgd_pkg::t_bpgd_out          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bpgd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [bpgd_pkg::MsW-1:0]     i_cfg_data
);

    logic [bpgd_pkg::MsW-1:0]  r_erase_hold;
    logic [bpgd_pkg::MsW-1:0]  r_short_max;
    logic [bpgd_pkg::TgtW-1:0] r_target;
    logic [bpgd_pkg::MsW-1:0]  r_seq_window;
    logic [bpgd_pkg::MsW-1:0]  r_quiet_gap;

    logic                       r_key_down,   n_key_down;
    logic [bpgd_pkg::TsW-1:0]   r_press_time, n_press_time;
    logic [bpgd_pkg::TsW-1:0]   r_first_time, n_first_time;
    logic [bpgd_pkg::TsW-1:0]   r_last_rel,   n_last_rel;
    logic [bpgd_pkg::CntW-1:0]  r_presses,    n_presses;
    logic                       r_spoiled,    n_spoiled;
    logic                       r_armed,      n_armed;

    logic                 r_in_valid;
    bpgd_pkg::t_bpgd_in   r_in;
    logic                 r_out_valid;
    bpgd_pkg::t_bpgd_out  r_out;
    bpgd_pkg::t_bpgd_out  n_out;

    logic                      advance;
    logic [bpgd_pkg::TsW-1:0]  held;
    logic [bpgd_pkg::TsW-1:0]  since_first;
    logic [bpgd_pkg::TsW-1:0]  since_rel;
    logic [bpgd_pkg::CntW-1:0] cnt_inc;
    logic                      hold_long;
    logic                      match;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign held        = r_in.timestamp_ms - r_press_time;
    assign since_first = r_in.timestamp_ms - r_first_time;
    assign since_rel   = r_in.timestamp_ms - r_last_rel;
    assign cnt_inc     = (r_presses < bpgd_pkg::PRESS_SAT) ? r_presses + 5'd1 : r_presses;
    assign hold_long   = held >= {16'd0, r_erase_hold};
    assign match       = !r_spoiled && (r_presses == {1'b0, r_target});

    always_comb begin
        n_key_down   = r_key_down;
        n_press_time = r_press_time;
        n_first_time = r_first_time;
        n_last_rel   = r_last_rel;
        n_presses    = r_presses;
        n_spoiled    = r_spoiled;
        n_armed      = r_armed;
        n_out.gesture = bpgd_pkg::GEST_NONE;
        case (r_in.operation)
            bpgd_pkg::OP_PRESS: begin
                if (!r_key_down) begin
                    n_key_down   = 1'b1;
                    n_press_time = r_in.timestamp_ms;
                    if (r_presses == '0) begin
                        n_first_time = r_in.timestamp_ms;
                    end
                end
            end
            bpgd_pkg::OP_RELEASE: begin
                if (r_key_down) begin
                    n_key_down = 1'b0;
                    if (r_armed || hold_long) begin
                        n_presses     = '0;
                        n_spoiled     = 1'b0;
                        n_armed       = 1'b0;
                        n_out.gesture = bpgd_pkg::GEST_ERASE;
                    end else begin
                        n_presses  = cnt_inc;
                        n_last_rel = r_in.timestamp_ms;
                        n_spoiled  = r_spoiled
                                   || (held >= {16'd0, r_short_max})
                                   || (cnt_inc > {1'b0, r_target})
                                   || (since_first > {16'd0, r_seq_window});
                    end
                end
            end
            bpgd_pkg::OP_TICK: begin
                if (r_key_down) begin
                    if (!r_armed && hold_long) begin
                        n_armed       = 1'b1;
                        n_out.gesture = bpgd_pkg::GEST_ARMED;
                    end
                end else if (r_presses != '0 && since_rel >= {16'd0, r_quiet_gap}) begin
                    n_presses = '0;
                    n_spoiled = 1'b0;
                    n_armed   = 1'b0;
                    if (match) begin
                        n_out.gesture = bpgd_pkg::GEST_PROVISION;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.busy_res = n_key_down || (n_presses != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_hold <= bpgd_pkg::RST_ERASE_HOLD;
            r_short_max  <= bpgd_pkg::RST_SHORT_MAX;
            r_target     <= bpgd_pkg::RST_TARGET;
            r_seq_window <= bpgd_pkg::RST_SEQ_WINDOW;
            r_quiet_gap  <= bpgd_pkg::RST_QUIET_GAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpgd_pkg::CFG_ERASE_HOLD: r_erase_hold <= i_cfg_data;
                bpgd_pkg::CFG_SHORT_MAX:  r_short_max  <= i_cfg_data;
                bpgd_pkg::CFG_TARGET:     r_target     <= i_cfg_data[bpgd_pkg::TgtW-1:0];
                bpgd_pkg::CFG_SEQ_WINDOW: r_seq_window <= i_cfg_data;
                bpgd_pkg::CFG_QUIET_GAP:  r_quiet_gap  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down   <= 1'b0;
            r_press_time <= '0;
            r_first_time <= '0;
            r_last_rel   <= '0;
            r_presses    <= '0;
            r_spoiled    <= 1'b0;
            r_armed      <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_key_down   <= n_key_down;
                r_press_time <= n_press_time;
                r_first_time <= n_first_time;
                r_last_rel   <= n_last_rel;
                r_presses    <= n_presses;
                r_spoiled    <= n_spoiled;
                r_armed      <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/bpgd_checker.sv @@
module bpgd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input bpgd_pkg::t_bpgd_out          o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    a_idle_gesture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.gesture == bpgd_pkg::GEST_ERASE
                     || o_out_data.gesture == bpgd_pkg::GEST_PROVISION)
        |-> !o_out_data.busy_res)
        else $error("erase or provision reported while still busy");

    a_armed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.gesture == bpgd_pkg::GEST_ARMED |-> o_out_data.busy_res)
        else $error("erase armed reported while key not held");

endmodule

bind button_press_gesture_detector_unit bpgd_checker u_bpgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
